>>> rtl/xxh_pkg.sv
// Package: XXH64 constants, types and helper functions.
`timescale 1ns / 1ps
package xxh_pkg;
    localparam logic [63:0] PRIME1 = 64'd11400714785074694791;
    localparam logic [63:0] PRIME2 = 64'd14029467366897019727;
    localparam logic [63:0] PRIME3 = 64'd1609587929392839161;
    localparam logic [63:0] PRIME4 = 64'd9650029242287828579;
    localparam logic [63:0] PRIME5 = 64'd2870177450012600261;
    localparam int LENGTH_BITS = 64;
    localparam int QUEUE_DEPTH = 2;
    localparam logic [0:0] ADDR_SEED = 1'b0;

    // One classified word as it travels from front to back.
    typedef struct packed {
        logic [63:0] word;
        logic [3:0]  nbytes;
        logic        last;
        logic        stripe;
    } t_item;

    function automatic logic [63:0] rotl(input logic [63:0] x, input int r);
        rotl = (x << r) | (x >> (64 - r));
    endfunction
endpackage

>>> rtl/xxh_front.sv
// Front end: accepts words, clamps byte counts and tags stripe completion.
`timescale 1ns / 1ps
module xxh_front import xxh_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_restart,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_data_word,
    input  logic [3:0]  i_valid_bytes,
    input  logic        i_last_word,
    output logic        o_valid,
    input  logic        i_ready,
    output t_item       o_item
);
    t_item r_q [QUEUE_DEPTH];
    logic [0:0] r_wp, r_rp;
    logic [1:0] r_cnt, n_cnt;
    logic [1:0] r_pos, n_pos;
    logic       push, pop;
    t_item      in_item;
    logic [3:0] nb;

    assign o_ready = (r_cnt != 2'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_comb begin
        nb = i_last_word ? ((i_valid_bytes > 4'd8) ? 4'd8 : i_valid_bytes) : 4'd8;
        in_item.word   = i_data_word;
        in_item.nbytes = nb;
        in_item.last   = i_last_word;
        in_item.stripe = (nb == 4'd8) && (r_pos == 2'd3);
        n_pos = r_pos;
        if (push) begin
            n_pos = i_last_word ? 2'd0 : r_pos + 2'd1;
        end
        n_cnt = r_cnt + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
            r_pos <= '0;
        end else begin
            r_cnt <= n_cnt;
            r_pos <= n_pos;
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
        end
        if (push) r_q[r_wp] <= in_item;
    end

`ifndef NO_ASSERTIONS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(QUEUE_DEPTH)) else $error("queue count overflow");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'(QUEUE_DEPTH) |-> !push) else $error("push into full queue");
    a_pos_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n || i_restart)
        push && i_last_word |=> r_pos == 2'd0) else $error("position not cleared");
`endif
endmodule

>>> rtl/xxh_back.sv
// Back end: sequencer with one shared multiplier for lanes, merge, tail and avalanche.
`timescale 1ns / 1ps
module xxh_back import xxh_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_restart,
    input  logic [63:0] i_seed,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_item       i_item,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_hash_value
);
    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_RND   = 9'b000000010, // acc + val*P2 (mult), then rot*P1
        S_RND2  = 9'b000000100,
        S_MERGE = 9'b000001000,
        S_FOLD  = 9'b000010000,
        S_TAIL  = 9'b000100000,
        S_AVAL  = 9'b001000000,
        S_STEP2 = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    // which operation S_STEP2, S_RND2 or S_AVAL finishes
    typedef enum logic [2:0] {
        OP_LANE, OP_MERGE, OP_FOLD, OP_FOUR, OP_BYTE, OP_AV1, OP_AV2
    } t_op;

    t_state r_state;
    t_op    r_op;
    logic [63:0] r_acc [4];
    logic [63:0] r_buf [4];
    logic [1:0]  r_nbuf;
    logic [LENGTH_BITS-1:0] r_len;
    logic        r_seen;
    logic [63:0] r_h, r_t, r_w;
    logic [3:0]  r_nv, r_bi;
    logic [2:0]  r_idx;
    logic        r_last;
    logic [63:0] r_out;
    logic        r_ovalid;
    logic [63:0] mul_a, mul_b, prod;
    logic [63:0] merge_sum;
    logic [1:0]  r_mph;
    logic [63:0] r_plo;
    logic [31:0] r_pmid;
    logic [31:0] m_x, m_y;
    logic [63:0] m_p;
    logic        mul_wait;
    logic        out_load;

    // low 64 bits of mul_a*mul_b from three 32x32 partial products, one per cycle
    assign m_x = (r_mph == 2'd1) ? mul_a[63:32] : mul_a[31:0];
    assign m_y = (r_mph == 2'd2) ? mul_b[63:32] : mul_b[31:0];
    assign m_p = m_x * m_y;
    assign prod = r_plo + {r_pmid, 32'd0};
    assign mul_wait = (r_state != S_IDLE) && (r_state != S_OUT) && (r_mph != 2'd3);
    assign out_load = (r_state == S_OUT) && (!r_ovalid || i_ready);

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;
    assign o_hash_value = r_out;
    assign merge_sum = rotl(r_acc[0], 1) + rotl(r_acc[1], 7)
                     + rotl(r_acc[2], 12) + rotl(r_acc[3], 18);

    always_comb begin
        mul_a = r_t;
        mul_b = PRIME1;
        case (r_state)
            S_RND, S_MERGE, S_FOLD: begin
                mul_a = r_t; mul_b = PRIME2;
            end
            S_TAIL: begin
                if (r_nv >= 4'd4 && r_bi == 4'd0) begin
                    mul_a = {32'd0, r_w[31:0]}; mul_b = PRIME1;
                end else begin
                    mul_a = {56'd0, r_w[7:0]}; mul_b = PRIME5;
                end
            end
            S_AVAL: begin
                mul_a = r_t; mul_b = (r_op == OP_AV1) ? PRIME2 : PRIME3;
            end
            S_STEP2: begin
                mul_a = r_t;
                mul_b = (r_op == OP_FOUR) ? PRIME2 : PRIME1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_nbuf   <= '0;
            r_len    <= '0;
            r_seen   <= 1'b0;
            r_acc[0] <= i_seed + PRIME1 + PRIME2;
            r_acc[1] <= i_seed + PRIME2;
            r_acc[2] <= i_seed;
            r_acc[3] <= i_seed - PRIME1;
            r_op     <= OP_LANE;
            r_mph    <= '0;
        end else begin
            if (out_load) r_ovalid <= 1'b1;
            else if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            if (mul_wait) begin
                // hold the state while the partial products build up
                r_mph <= r_mph + 2'd1;
                case (r_mph)
                    2'd0:    r_plo  <= m_p;
                    2'd1:    r_pmid <= m_p[31:0];
                    default: r_pmid <= r_pmid + m_p[31:0];
                endcase
            end else begin
                r_mph <= '0;
                case (r_state)
                    S_IDLE: if (i_valid) begin
                        r_w      <= i_item.word;
                        r_nv     <= i_item.nbytes;
                        r_last   <= i_item.last;
                        r_len    <= r_len + LENGTH_BITS'(i_item.nbytes);
                        r_idx    <= '0;
                        if (i_item.nbytes == 4'd8) r_buf[r_nbuf] <= i_item.word;
                        if (i_item.stripe) begin
                            r_t     <= r_buf[0];
                            r_state <= S_RND;
                        end else if (i_item.last) begin
                            r_state <= S_MERGE;
                            r_t     <= r_acc[0];
                        end else begin
                            r_nbuf  <= r_nbuf + 2'd1;
                        end
                    end
                    S_RND: begin
                        // acc + val*P2, rotate, then *P1 in next step
                        r_t     <= rotl(r_acc[r_idx[1:0]] + prod, 31);
                        r_op    <= OP_LANE;
                        r_state <= S_STEP2;
                    end
                    S_MERGE: begin
                        if (!r_seen) begin
                            r_h <= i_seed + PRIME5 + 64'(r_len);
                            r_idx <= '0;
                            r_bi  <= '0;
                            r_state <= (r_nbuf != 2'd0) ? S_FOLD : S_TAIL;
                            r_t   <= r_buf[0];
                        end else begin
                            if (r_idx == 3'd0) r_h <= merge_sum;
                            r_t     <= rotl(prod, 31);
                            r_op    <= OP_MERGE;
                            r_state <= S_STEP2;
                        end
                    end
                    S_FOLD: begin
                        r_t     <= rotl(prod, 31);
                        r_op    <= OP_FOLD;
                        r_state <= S_STEP2;
                    end
                    S_TAIL: begin
                        if (r_nv == 4'd8) begin
                            r_t <= r_w; r_state <= S_FOLD; r_nv <= 4'd0;
                            r_idx <= 3'd4;
                        end else if (r_bi >= r_nv) begin
                            r_t <= r_h ^ (r_h >> 33);
                            r_op <= OP_AV1;
                            r_state <= S_AVAL;
                        end else if (r_nv >= 4'd4 && r_bi == 4'd0) begin
                            r_t <= rotl(r_h ^ prod, 23);
                            r_op <= OP_FOUR;
                            r_w <= r_w >> 32;
                            r_bi <= 4'd4;
                            r_state <= S_STEP2;
                        end else begin
                            r_t <= rotl(r_h ^ prod, 11);
                            r_op <= OP_BYTE;
                            r_w <= r_w >> 8;
                            r_bi <= r_bi + 4'd1;
                            r_state <= S_STEP2;
                        end
                    end
                    S_AVAL: begin
                        if (r_op == OP_AV1) begin
                            r_t  <= prod ^ (prod >> 29);
                            r_op <= OP_AV2;
                        end else begin
                            r_h      <= prod ^ (prod >> 32);
                            r_state  <= S_OUT;
                        end
                    end
                    S_STEP2: begin
                        case (r_op)
                            OP_LANE: begin
                                r_acc[r_idx[1:0]] <= prod;
                                if (r_idx == 3'd3) begin
                                    r_seen <= 1'b1;
                                    r_nbuf <= '0;
                                    r_idx  <= '0;
                                    if (r_last) begin
                                        r_nv    <= 4'd0;
                                        r_state <= S_MERGE;
                                        r_t     <= r_acc[0];
                                    end else r_state <= S_IDLE;
                                end else begin
                                    r_idx   <= r_idx + 3'd1;
                                    r_t     <= (r_idx == 3'd2) ? r_w : r_buf[r_idx[1:0] + 2'd1];
                                    r_state <= S_RND;
                                end
                            end
                            OP_MERGE: begin
                                r_h <= ((r_idx == 3'd0) ? merge_sum : r_h) ^ prod;
                                r_t <= ((r_idx == 3'd0) ? merge_sum : r_h) ^ prod;
                                r_op <= OP_FOUR; // reuse: finish with *P1+P4
                                r_state <= S_RND2;
                            end
                            OP_FOLD: begin
                                r_t  <= rotl(r_h ^ prod, 27);
                                r_op <= OP_FOLD;
                                r_state <= S_RND2;
                            end
                            OP_FOUR: begin
                                r_h <= prod + PRIME3;
                                r_state <= S_TAIL;
                            end
                            OP_BYTE: begin
                                r_h <= prod;
                                r_state <= S_TAIL;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                    S_RND2: begin
                        // h*P1 + P4 for merge (r_op OP_FOUR) or fold (OP_FOLD)
                        if (r_op == OP_FOLD) begin
                            r_h <= prod + PRIME4;
                            if (r_idx == 3'd4) begin
                                r_bi <= '0; r_state <= S_TAIL;
                            end else if (r_idx[1:0] + 2'd1 < r_nbuf) begin
                                r_idx <= r_idx + 3'd1;
                                r_t <= r_buf[r_idx[1:0] + 2'd1];
                                r_state <= S_FOLD;
                            end else begin
                                r_bi <= '0; r_state <= S_TAIL;
                            end
                        end else begin
                            if (r_idx == 3'd3) begin
                                r_h <= prod + PRIME4 + 64'(r_len);
                                r_idx <= '0;
                                r_bi  <= '0;
                                r_t   <= r_buf[0];
                                r_state <= (r_nbuf != 2'd0) ? S_FOLD : S_TAIL;
                            end else begin
                                r_h   <= prod + PRIME4;
                                r_idx <= r_idx + 3'd1;
                                r_t   <= r_acc[r_idx[1:0] + 2'd1];
                                r_state <= S_MERGE;
                            end
                        end
                    end
                    S_OUT: begin
                        // hold the digest until the output register is free
                        if (out_load) begin
                            r_out    <= r_h;
                            r_state  <= S_IDLE;
                            r_nbuf   <= '0;
                            r_len    <= '0;
                            r_seen   <= 1'b0;
                            r_acc[0] <= i_seed + PRIME1 + PRIME2;
                            r_acc[1] <= i_seed + PRIME2;
                            r_acc[2] <= i_seed;
                            r_acc[3] <= i_seed - PRIME1;
                        end
                    end
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n || i_restart)
        r_ovalid && !i_ready |=> r_ovalid && $stable(r_out)) else $error("result dropped");
    a_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !o_ready) else $error("ready while busy");
    a_out_from: assert property (@(posedge i_clk) disable iff (!i_rst_n || i_restart)
        $rose(r_ovalid) |-> $past(r_state) == S_OUT) else $error("bad result source");
`endif
endmodule

>>> rtl/xxh_cfg.sv
// APB register block holding the seed.
`timescale 1ns / 1ps
module xxh_cfg import xxh_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    output logic [63:0] o_seed,
    output logic        o_restart
);
    logic [63:0] r_seed;
    assign pready    = 1'b1;
    assign o_restart = psel && penable && pwrite && (paddr == ADDR_SEED);
    assign prdata    = (paddr == ADDR_SEED) ? r_seed : 64'd0;
    assign o_seed    = o_restart ? pwdata : r_seed;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_seed <= '0;
        else if (o_restart) r_seed <= pwdata;
    end
endmodule

>>> rtl/xxhash64_stream.sv
// Top level: streaming XXH64 digest engine.
//  channel | direction | signals
//  in      | sink      | i_valid/o_ready, i_data_word, i_valid_bytes, i_last_word
//  out     | source    | o_valid/i_ready, o_hash_value
//  cfg     | APB slave | psel, penable, pwrite, paddr, pwdata, prdata, pready
// Every multiply runs on one shared 32x32 multiplier (three partial products,
// then the sum). A non-last word that does not complete a stripe is only
// buffered; a stripe word runs four lane rounds of two multiplies. A last word
// runs the merge, up to three tail words and up to seven tail bytes.
// A two-entry queue lets input continue while the back end works; the back end
// stalls only when a new digest is ready while the previous one still waits.
// Reset is synchronous; a seed write restarts the message.
`timescale 1ns / 1ps
module xxhash64_stream import xxh_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_data_word,
    input  logic [3:0]  i_valid_bytes,
    input  logic        i_last_word,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_hash_value,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:3]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    logic [63:0] seed;
    logic        restart, q_valid, q_ready;
    t_item       q_item;

    xxh_cfg u_cfg (.i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr(paddr[3:3]),
        .pwdata, .prdata, .pready, .o_seed(seed), .o_restart(restart));
    xxh_front u_front (.i_clk, .i_rst_n, .i_restart(restart), .i_valid, .o_ready,
        .i_data_word, .i_valid_bytes, .i_last_word, .o_valid(q_valid),
        .i_ready(q_ready), .o_item(q_item));
    xxh_back u_back (.i_clk, .i_rst_n, .i_restart(restart), .i_seed(seed),
        .i_valid(q_valid), .o_ready(q_ready), .i_item(q_item), .o_valid,
        .i_ready, .o_hash_value);
endmodule

>>> tb/tb_xxhash64_stream.sv
// Testbench for xxhash64_stream: directed and random messages checked against an XXH64 predictor.
`timescale 1ns / 1ps
module tb_xxhash64_stream;
    import xxh_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 60;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [63:0] i_data_word;
    logic [3:0]  i_valid_bytes;
    logic        i_last_word;
    logic        o_valid;
    logic        i_ready;
    logic [63:0] o_hash_value;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:3]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    xxhash64_stream u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_data_word   (i_data_word),
        .i_valid_bytes (i_valid_bytes),
        .i_last_word   (i_last_word),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_hash_value  (o_hash_value),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // predictor state
    logic [63:0] cur_seed;
    logic [63:0] lanes [4];
    logic [63:0] stripe_words [4];
    int unsigned word_count;
    logic [63:0] msg_len;
    logic        have_stripe;

    logic [63:0] digest_q [$];
    int          errors;
    int          idle_cycles;
    bit          no_idle;
    bit          sink_stall_en;

    function automatic logic [63:0] rol(input logic [63:0] x, input int r);
        return (x << r) | (x >> (64 - r));
    endfunction

    function automatic logic [63:0] xround(input logic [63:0] acc, input logic [63:0] val);
        acc = acc + val * PRIME2;
        return rol(acc, 31) * PRIME1;
    endfunction

    function automatic logic [63:0] fold_full(input logic [63:0] h, input logic [63:0] w);
        h = h ^ xround(64'd0, w);
        return rol(h, 27) * PRIME1 + PRIME4;
    endfunction

    task automatic restart_message();
        lanes[0] = cur_seed + PRIME1 + PRIME2;
        lanes[1] = cur_seed + PRIME2;
        lanes[2] = cur_seed;
        lanes[3] = cur_seed - PRIME1;
        for (int k = 0; k < 4; k++) stripe_words[k] = 64'd0;
        word_count  = 0;
        msg_len     = 64'd0;
        have_stripe = 1'b0;
    endtask

    task automatic absorb_word(input logic [63:0] w);
        stripe_words[word_count] = w;
        if (word_count == 3) begin
            for (int k = 0; k < 4; k++) lanes[k] = xround(lanes[k], stripe_words[k]);
            word_count  = 0;
            have_stripe = 1'b1;
        end else begin
            word_count++;
        end
    endtask

    // advance the predictor by one word; push a digest on the last word
    task automatic predict_digest(input logic [63:0] w, input logic [3:0] vb, input logic lw);
        int unsigned nv;
        logic [63:0] h;
        if (!lw) begin
            msg_len = msg_len + 64'd8;
            absorb_word(w);
            return;
        end
        nv = (vb > 8) ? 8 : vb;
        msg_len = msg_len + 64'(nv);
        if (nv == 8 && word_count == 3) begin
            absorb_word(w);
            nv = 0;
        end
        if (have_stripe) begin
            h = rol(lanes[0], 1) + rol(lanes[1], 7) + rol(lanes[2], 12) + rol(lanes[3], 18);
            for (int k = 0; k < 4; k++) begin
                h = h ^ xround(64'd0, lanes[k]);
                h = h * PRIME1 + PRIME4;
            end
        end else begin
            h = cur_seed + PRIME5;
        end
        h = h + msg_len;
        for (int k = 0; k < word_count; k++) h = fold_full(h, stripe_words[k]);
        if (nv == 8) begin
            h = fold_full(h, w);
        end else begin
            int unsigned b;
            b = 0;
            if (nv >= 4) begin
                h = h ^ ({32'd0, w[31:0]} * PRIME1);
                h = rol(h, 23) * PRIME2 + PRIME3;
                b = 4;
            end
            for (; b < nv; b++) begin
                h = h ^ ({56'd0, w[8*b +: 8]} * PRIME5);
                h = rol(h, 11) * PRIME1;
            end
        end
        h = h ^ (h >> 33);
        h = h * PRIME2;
        h = h ^ (h >> 29);
        h = h * PRIME3;
        h = h ^ (h >> 32);
        digest_q.push_back(h);
        restart_message();
    endtask

    // output side: check each digest transaction and stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (digest_q.size() == 0) begin
                $display("%0t: unexpected digest, expected none, actual %h", $time, o_hash_value);
                errors++;
            end else begin
                logic [63:0] want;
                want = digest_q.pop_front();
                if (o_hash_value !== want) begin
                    $display("%0t: hash_value mismatch, expected %h, actual %h",
                             $time, want, o_hash_value);
                    errors++;
                end
            end
        end
    end

    initial begin
        int stall;
        i_ready = 1'b1;
        stall   = 0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                stall--;
                i_ready <= 1'b0;
            end else if (sink_stall_en && !no_idle && $urandom_range(0, 5) == 0) begin
                stall   = $urandom_range(0, 2);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // watchdog: count cycles with no transaction on any channel
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || psel) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_seed(input logic [63:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_SEED;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_seed = value;
        restart_message();
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(input logic [63:0] w, input logic [3:0] vb, input logic lw);
        if (!no_idle && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_data_word   <= w;
        i_valid_bytes <= vb;
        i_last_word   <= lw;
        do @(posedge i_clk); while (!o_ready);
        predict_digest(w, vb, lw);
        @(negedge i_clk);
    endtask

    // drop valid at once so the last word is not taken twice
    task automatic drain_digests();
        i_valid <= 1'b0;
        while (digest_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // random message: mostly short, a few long enough for several stripes
    task automatic send_message(input int n_full);
        logic [3:0] vb;
        for (int k = 0; k < n_full; k++) send_word({$urandom, $urandom}, 4'($urandom), 1'b0);
        vb = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
        send_word({$urandom, $urandom}, vb, 1'b1);
    endtask

    typedef struct {
        logic [63:0] word;
        logic [3:0]  nbytes;
        logic        last;
        bit          known;
        logic [63:0] digest;
    } t_row;

    t_row dir_rows [] = '{
        // empty message with seed 0
        '{64'h0, 4'd0, 1'b1, 1'b1, 64'hEF46DB3751D8E999},
        '{64'hFFFF_FFFF_FFFF_FFFF, 4'd1, 1'b1, 1'b0, 64'h0},
        '{64'hFFFF_FFFF_FFFF_FFFF, 4'd3, 1'b1, 1'b0, 64'h0},
        '{64'h0123_4567_89AB_CDEF, 4'd4, 1'b1, 1'b0, 64'h0},
        '{64'hFFFF_FFFF_FFFF_FFFF, 4'd7, 1'b1, 1'b0, 64'h0},
        '{64'h0, 4'd8, 1'b1, 1'b0, 64'h0},
        '{64'hA5A5_5A5A_0F0F_F0F0, 4'd15, 1'b1, 1'b0, 64'h0},
        '{64'hFFFF_FFFF_FFFF_FFFF, 4'd9, 1'b1, 1'b0, 64'h0},
        // three full words then a full last word completing the stripe
        '{64'h1111_1111_1111_1111, 4'd0, 1'b0, 1'b0, 64'h0},
        '{64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b0, 1'b0, 64'h0},
        '{64'h0, 4'd8, 1'b0, 1'b0, 64'h0},
        '{64'hDEAD_BEEF_CAFE_F00D, 4'd8, 1'b1, 1'b0, 64'h0},
        // one stripe then tail words and a short last word
        '{64'h1, 4'd8, 1'b0, 1'b0, 64'h0},
        '{64'h2, 4'd8, 1'b0, 1'b0, 64'h0},
        '{64'h3, 4'd8, 1'b0, 1'b0, 64'h0},
        '{64'h4, 4'd8, 1'b0, 1'b0, 64'h0},
        '{64'h5, 4'd8, 1'b0, 1'b0, 64'h0},
        '{64'h6, 4'd8, 1'b0, 1'b0, 64'h0},
        '{64'h7766_5544_3322_1100, 4'd6, 1'b1, 1'b0, 64'h0},
        // stripe then an empty last word
        '{64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b0, 1'b0, 64'h0},
        '{64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b0, 1'b0, 64'h0},
        '{64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b0, 1'b0, 64'h0},
        '{64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b0, 1'b0, 64'h0},
        '{64'h0, 4'd0, 1'b1, 1'b0, 64'h0}
    };

    initial begin
        int n_items;
        logic [63:0] seeds [4];
        errors        = 0;
        idle_cycles   = 0;
        no_idle       = 1'b0;
        sink_stall_en = 1'b1;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_data_word   = 64'd0;
        i_valid_bytes = 4'd0;
        i_last_word   = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = ADDR_SEED;
        pwdata        = 64'd0;
        cur_seed      = 64'd0;
        restart_message();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < dir_rows.size(); r++) begin
            send_word(dir_rows[r].word, dir_rows[r].nbytes, dir_rows[r].last);
            if (dir_rows[r].known && digest_q.size() != 0 &&
                digest_q[$] !== dir_rows[r].digest) begin
                $display("%0t: predictor mismatch on row %0d, expected %h, actual %h",
                         $time, r, dir_rows[r].digest, digest_q[$]);
                errors++;
            end
        end
        drain_digests();

        seeds[0] = 64'hFFFF_FFFF_FFFF_FFFF;
        seeds[1] = 64'd1;
        seeds[2] = {$urandom, $urandom};
        seeds[3] = 64'd0;
        n_items = 0;
        for (int ph = 0; ph < 4; ph++) begin
            write_seed(seeds[ph]);
            if (ph == 1) begin
                // seed rewrite mid-message restarts the message
                send_word({$urandom, $urandom}, 4'd8, 1'b0);
                send_word({$urandom, $urandom}, 4'd8, 1'b0);
                drain_digests();
                write_seed(seeds[ph]);
            end
            if (ph == 3) no_idle = 1'b1;
            sink_stall_en = (ph != 3);
            while (n_items < (ph + 1) * 430) begin
                int n_full;
                if ($urandom_range(0, 19) == 0) n_full = $urandom_range(8, 24);
                else n_full = $urandom_range(0, 7);
                send_message(n_full);
                n_items += n_full + 1;
                if (ph == 0 && n_items > 200 && n_items - (n_full + 1) <= 200) begin
                    // pause until every digest has come back
                    i_valid <= 1'b0;
                    while (digest_q.size() != 0) @(negedge i_clk);
                end
            end
            drain_digests();
        end

        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
